FILE: rtl/upd_pkg.sv
// Shared types, constants and tables for the Unix-seconds to packed-date pipeline.
package upd_pkg;

  // Accepted seconds range: 0001-01-01 00:00:00 through 9999-12-31 23:59:59
  localparam logic signed [63:0] SEC_LO = -64'sd62135596800;
  localparam logic signed [63:0] SEC_HI = 64'sd253402300799;

  // Reciprocal constants: q = (x * RCP) >> K with K = width(x) + ceil(log2(divisor))
  localparam int DAY_K = 42;  // x < 2^32, divisor 675 (86400 = 675 * 128)
  localparam logic [32:0] RCP_DAY = 33'(((65'd1 << DAY_K) + 65'd674) / 65'd675);

  localparam int ERA_K = 40;  // x < 2^22, divisor 146097
  localparam logic [22:0] RCP_ERA = 23'(((64'd1 << ERA_K) + 64'd146096) / 64'd146097);

  localparam int WK_K = 25;   // x < 2^22, divisor 7
  localparam logic [22:0] RCP_WK = 23'(((64'd1 << WK_K) + 64'd6) / 64'd7);

  localparam int C4Y_K = 29;  // x < 2^18, divisor 1460
  localparam logic [18:0] RCP_C4Y = 19'(((64'd1 << C4Y_K) + 64'd1459) / 64'd1460);

  localparam int YR_K = 27;   // x < 2^18, divisor 365
  localparam logic [18:0] RCP_YR = 19'(((64'd1 << YR_K) + 64'd364) / 64'd365);

  localparam int CEN_K = 16;  // x < 2^9, divisor 100
  localparam logic [9:0] RCP_CEN = 10'(((64'd1 << CEN_K) + 64'd99) / 64'd100);

  localparam int MON_K = 19;  // x < 2^11, divisor 153
  localparam logic [11:0] RCP_MON = 12'(((64'd1 << MON_K) + 64'd152) / 64'd153);

  // Civil-from-days constants
  localparam logic [21:0] MARCH_SHIFT  = 22'd306;     // 0000-03-01 to 0001-01-01
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] CENT_1       = 18'd36524;
  localparam logic [17:0] CENT_2       = 18'd73048;
  localparam logic [17:0] CENT_3       = 18'd109572;
  localparam logic [17:0] ERA_LAST     = 18'd146096;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam logic [8:0]  YRS_PER_ERA  = 9'd400;
  localparam logic [3:0]  MP_JAN       = 4'd10;       // first March-based index of January
  localparam logic [3:0]  MONTH_FEB    = 4'd2;

  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  // Day count since 0001-01-01 plus range flag
  typedef struct packed {
    logic        ok;
    logic [21:0] days;
  } days_t;

  // Era split: era, day of era, year of era and weekday
  typedef struct packed {
    logic        ok;
    logic [4:0]  era;
    logic [17:0] doe;
    logic [8:0]  yoe;
    logic [2:0]  wd;
  } yoe_t;

  // First day of March-based month mp within the March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/upd_in_if.sv
// Timestamp input channel: valid/ready handshake with signed seconds payload.
interface upd_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

FILE: rtl/upd_out_if.sv
// Date result channel: valid/ready handshake with the packed date fields.
interface upd_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] packed_date;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  day_of_week;
  logic        is_working_day;
  logic        valid_res;

  modport source (
    output valid, output packed_date, output year, output month, output day_of_month,
    output day_of_week, output is_working_day, output valid_res, input ready
  );
  modport sink (
    input valid, input packed_date, input year, input month, input day_of_month,
    input day_of_week, input is_working_day, input valid_res, output ready
  );
endinterface

FILE: rtl/unix_seconds_to_packed_date.sv
// Top level: streaming conversion of Unix seconds to a packed Gregorian date.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------------
//   stamp    | in        | unix_seconds (signed 64)
//   civil    | out       | packed_date, year, month, day_of_month, day_of_week,
//            |           | is_working_day, valid_res
//
// One timestamp is taken every cycle unless a stalled output has backed the pipeline
// up to its input; each result passes through the ten register stages (two for the
// day count, four for the era split, four for the calendar fields and output
// register).
// Reset clears only the stage valid bits. A stalled output holds every stage
// whose successor is full; empty stages keep filling, so nothing is lost or repeated.
module unix_seconds_to_packed_date (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    stamp,
  upd_out_if.source civil
);

  logic           days_valid;
  logic           days_ready;
  upd_pkg::days_t days_data;
  logic           yoe_valid;
  logic           yoe_ready;
  upd_pkg::yoe_t  yoe_data;

  upd_day_stage u_day (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stamp.valid),
    .up_ready (stamp.ready),
    .up_secs  (stamp.unix_seconds),
    .dn_valid (days_valid),
    .dn_ready (days_ready),
    .dn_data  (days_data)
  );

  upd_era_stage u_era (
    .clk      (clk),
    .rst      (rst),
    .up_valid (days_valid),
    .up_ready (days_ready),
    .up_data  (days_data),
    .dn_valid (yoe_valid),
    .dn_ready (yoe_ready),
    .dn_data  (yoe_data)
  );

  upd_civil_stage u_civil (
    .clk      (clk),
    .rst      (rst),
    .up_valid (yoe_valid),
    .up_ready (yoe_ready),
    .up_data  (yoe_data),
    .civil    (civil)
  );

endmodule

FILE: rtl/upd_day_stage.sv
// Range check and floor division of seconds by 86400 (two stages).
module upd_day_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic signed [63:0] up_secs,
  output logic               dn_valid,
  input  logic               dn_ready,
  output upd_pkg::days_t     dn_data
);

  logic        v1;
  logic        ok1;
  logic [31:0] x1;
  logic        v2;
  upd_pkg::days_t d2;

  logic        adv1;
  logic        adv2;
  logic        in_range;
  logic [63:0] shifted;
  logic [64:0] prod;

  // Advance a stage when it is empty or its successor moves
  assign adv2     = !v2 || dn_ready;
  assign adv1     = !v1 || adv2;
  assign up_ready = adv1;

  // Offset to 0001-01-01 so the quotient is a plain unsigned one
  always_comb begin
    in_range = (up_secs >= upd_pkg::SEC_LO) && (up_secs <= upd_pkg::SEC_HI);
    shifted  = 64'(up_secs - upd_pkg::SEC_LO);
    prod     = 65'(x1) * 65'(upd_pkg::RCP_DAY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= up_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  // Payload: divide by 128 with a shift, then by 675 with a reciprocal
  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      ok1 <= in_range;
      x1  <= shifted[38:7];
    end
    if (adv2 && v1) begin
      d2.ok   <= ok1;
      d2.days <= prod[upd_pkg::DAY_K + 21:upd_pkg::DAY_K];
    end
  end

  assign dn_valid = v2;
  assign dn_data  = d2;

endmodule

FILE: rtl/upd_era_stage.sv
// Era, day of era, weekday and year of era (four stages).
module upd_era_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  upd_pkg::days_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output upd_pkg::yoe_t  dn_data
);

  // Stage 3
  logic        v3;
  logic        ok3;
  logic [21:0] z3;
  logic [21:0] days3;
  logic [4:0]  era3;
  // Stage 4
  logic        v4;
  logic        ok4;
  logic [4:0]  era4;
  logic [17:0] doe4;
  logic [21:0] t4;
  logic [19:0] wq4;
  // Stage 5
  logic        v5;
  logic        ok5;
  logic [4:0]  era5;
  logic [17:0] doe5;
  logic [17:0] n5;
  logic [2:0]  wd5;
  // Stage 6
  logic        v6;
  upd_pkg::yoe_t r6;

  logic        adv3;
  logic        adv4;
  logic        adv5;
  logic        adv6;
  logic [21:0] z;
  logic [44:0] era_prod;
  logic [21:0] doe_full;
  logic [21:0] t;
  logic [44:0] wk_prod;
  logic [36:0] c4y_prod;
  logic [2:0]  cent;
  logic [18:0] n_full;
  logic [2:0]  wd;
  logic [36:0] yr_prod;

  assign adv6     = !v6 || dn_ready;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign up_ready = adv3;

  always_comb begin
    // Shift to a March-based count and split off the 400-year era
    z        = up_data.days + upd_pkg::MARCH_SHIFT;
    era_prod = 45'(z) * 45'(upd_pkg::RCP_ERA);
    // Remainder within the era; weekday quotient (0001-01-01 was a Monday)
    doe_full = z3 - 22'(era3) * 22'(upd_pkg::DAYS_PER_ERA);
    t        = days3 + 22'd1;
    wk_prod  = 45'(t) * 45'(upd_pkg::RCP_WK);
    // Leap corrections: 4-year cycles, centuries, last day of the era
    c4y_prod = 37'(doe4) * 37'(upd_pkg::RCP_C4Y);
    cent     = 3'(doe4 >= upd_pkg::CENT_1) + 3'(doe4 >= upd_pkg::CENT_2)
             + 3'(doe4 >= upd_pkg::CENT_3) + 3'(doe4 >= upd_pkg::ERA_LAST);
    n_full   = 19'(doe4) - 19'(c4y_prod[upd_pkg::C4Y_K + 7:upd_pkg::C4Y_K]) + 19'(cent)
             - 19'(doe4 == upd_pkg::ERA_LAST);
    wd       = t4[2:0] - 3'(wq4[2:0] * 3'd7);
    // Year of era
    yr_prod  = 37'(n5) * 37'(upd_pkg::RCP_YR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (adv3) begin
        v3 <= up_valid;
      end
      if (adv4) begin
        v4 <= v3;
      end
      if (adv5) begin
        v5 <= v4;
      end
      if (adv6) begin
        v6 <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && up_valid) begin
      ok3   <= up_data.ok;
      z3    <= z;
      days3 <= up_data.days;
      era3  <= era_prod[upd_pkg::ERA_K + 4:upd_pkg::ERA_K];
    end
    if (adv4 && v3) begin
      ok4  <= ok3;
      era4 <= era3;
      doe4 <= doe_full[17:0];
      t4   <= t;
      wq4  <= wk_prod[upd_pkg::WK_K + 19:upd_pkg::WK_K];
    end
    if (adv5 && v4) begin
      ok5  <= ok4;
      era5 <= era4;
      doe5 <= doe4;
      n5   <= n_full[17:0];
      wd5  <= wd;
    end
    if (adv6 && v5) begin
      r6.ok  <= ok5;
      r6.era <= era5;
      r6.doe <= doe5;
      r6.yoe <= yr_prod[upd_pkg::YR_K + 8:upd_pkg::YR_K];
      r6.wd  <= wd5;
    end
  end

  assign dn_valid = v6;
  assign dn_data  = r6;

endmodule

FILE: rtl/upd_civil_stage.sv
// Day of year, month, day, year and the packed result register (four stages).
module upd_civil_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  upd_pkg::yoe_t up_data,
  upd_out_if.source     civil
);

  // Stage 7
  logic        v7;
  logic        ok7;
  logic [4:0]  era7;
  logic [8:0]  yoe7;
  logic [8:0]  doy7;
  logic [2:0]  wd7;
  // Stage 8
  logic        v8;
  logic        ok8;
  logic [4:0]  era8;
  logic [8:0]  yoe8;
  logic [8:0]  doy8;
  logic [3:0]  mp8;
  logic [2:0]  wd8;
  // Stage 9
  logic        v9;
  logic        ok9;
  logic [13:0] y9;
  logic [3:0]  m9;
  logic [4:0]  d9;
  logic [2:0]  wd9;
  // Output register
  logic        v10;
  logic [26:0] packed10;
  logic [13:0] y10;
  logic [3:0]  m10;
  logic [4:0]  d10;
  logic [2:0]  wd10;
  logic        work10;
  logic        ok10;

  logic        adv7;
  logic        adv8;
  logic        adv9;
  logic        adv10;
  logic [18:0] cen_prod;
  logic [17:0] yr_days;
  logic [17:0] doy_full;
  logic [10:0] w;
  logic [22:0] mon_prod;
  logic [8:0]  d_full;
  logic [3:0]  m;
  logic [13:0] y;
  logic [26:0] packed_sum;

  assign adv10    = !v10 || civil.ready;
  assign adv9     = !v9 || adv10;
  assign adv8     = !v8 || adv9;
  assign adv7     = !v7 || adv8;
  assign up_ready = adv7;

  always_comb begin
    // Day of the March-based year
    cen_prod = 19'(up_data.yoe) * 19'(upd_pkg::RCP_CEN);
    yr_days  = 18'(up_data.yoe) * 18'(upd_pkg::DAYS_PER_YR) + 18'(up_data.yoe[8:2])
             - 18'(cen_prod[upd_pkg::CEN_K + 2:upd_pkg::CEN_K]);
    doy_full = up_data.doe - yr_days;
    // March-based month index
    w        = 11'(doy7) * 11'd5 + 11'd2;
    mon_prod = 23'(w) * 23'(upd_pkg::RCP_MON);
    // Day, calendar month and year
    d_full   = doy8 - upd_pkg::month_start(mp8) + 9'd1;
    m        = (mp8 < upd_pkg::MP_JAN) ? mp8 + 4'd3 : mp8 - 4'd9;
    y        = 14'(yoe8) + 14'(era8) * 14'(upd_pkg::YRS_PER_ERA)
             + 14'(m <= upd_pkg::MONTH_FEB);
    // Decimal packing
    packed_sum = 27'(y9) * 27'd10000 + 27'(m9) * 27'd100 + 27'(d9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (adv7) begin
        v7 <= up_valid;
      end
      if (adv8) begin
        v8 <= v7;
      end
      if (adv9) begin
        v9 <= v8;
      end
      if (adv10) begin
        v10 <= v9;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv7 && up_valid) begin
      ok7  <= up_data.ok;
      era7 <= up_data.era;
      yoe7 <= up_data.yoe;
      doy7 <= doy_full[8:0];
      wd7  <= up_data.wd;
    end
    if (adv8 && v7) begin
      ok8  <= ok7;
      era8 <= era7;
      yoe8 <= yoe7;
      doy8 <= doy7;
      mp8  <= mon_prod[upd_pkg::MON_K + 3:upd_pkg::MON_K];
      wd8  <= wd7;
    end
    if (adv9 && v8) begin
      ok9 <= ok8;
      y9  <= y;
      m9  <= m;
      d9  <= d_full[4:0];
      wd9 <= wd8;
    end
    // Zero every field of an out-of-range date
    if (adv10 && v9) begin
      ok10     <= ok9;
      packed10 <= ok9 ? packed_sum : 27'd0;
      y10      <= ok9 ? y9 : 14'd0;
      m10      <= ok9 ? m9 : 4'd0;
      d10      <= ok9 ? d9 : 5'd0;
      wd10     <= ok9 ? wd9 : upd_pkg::WD_SUNDAY;
      work10   <= ok9 && (wd9 != upd_pkg::WD_SUNDAY) && (wd9 != upd_pkg::WD_SATURDAY);
    end
  end

  assign civil.valid          = v10;
  assign civil.packed_date    = packed10;
  assign civil.year           = y10;
  assign civil.month          = m10;
  assign civil.day_of_month   = d10;
  assign civil.day_of_week    = wd10;
  assign civil.is_working_day = work10;
  assign civil.valid_res      = ok10;

endmodule

FILE: sim/tb_civil_date_checker.sv
// Checker for the seconds-to-date pipeline: predicts each civil date and compares results.
`timescale 1ns / 100ps

module civil_date_checker (
  input  logic clk,
  input  logic rst,
  upd_in_if    stamp,
  upd_out_if   civil,
  output int   fail_count,
  output int   dates_pending,
  output int   dates_checked,
  output int   dates_out_of_range
);

  // Calendar anchors, in days relative to 1970-01-01
  localparam longint SECS_PER_DAY    = 86400;
  localparam longint FIRST_VALID_DAY = -719162;   // 0001-01-01
  localparam longint LAST_VALID_DAY  = 2932896;   // 9999-12-31
  localparam longint MARCH0_OFFSET   = 719468;    // shift to 0000-03-01
  localparam longint ERA_DAYS        = 146097;

  typedef struct packed {
    logic [26:0] packed_date;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic        is_working_day;
    logic        valid_res;
  } civil_date_t;

  civil_date_t dates_due[$];
  int          mismatches;
  int          checked;
  int          out_of_range;

  // Work out the UTC Gregorian date of a signed timestamp
  function automatic civil_date_t civil_date_of(input logic signed [63:0] secs);
    civil_date_t r;
    longint      day_num, rem, z, era, doe, yoe, doy, mp, d, m, y, wd;
    r = '0;
    day_num = secs / SECS_PER_DAY;
    rem = secs % SECS_PER_DAY;
    // round toward minus infinity
    if (rem < 0) day_num = day_num - 1;
    if (day_num < FIRST_VALID_DAY || day_num > LAST_VALID_DAY) return r;
    z   = day_num + MARCH0_OFFSET;
    era = z / ERA_DAYS;
    doe = z - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    // 0001-01-01 fell on a Monday
    wd  = (day_num - FIRST_VALID_DAY + 1) % 7;
    r.packed_date    = 27'(y * 10000 + m * 100 + d);
    r.year           = 14'(y);
    r.month          = 4'(m);
    r.day_of_month   = 5'(d);
    r.day_of_week    = 3'(wd);
    r.is_working_day = (wd >= 1 && wd <= 5);
    r.valid_res      = 1'b1;
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [26:0] want,
                                       input logic [26:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    mismatches = 0;
    checked = 0;
    out_of_range = 0;
    fail_count = 0;
    dates_pending = 0;
    dates_checked = 0;
    dates_out_of_range = 0;
  end

  // Compare each result transfer, then queue the date for each stamp transfer
  always @(posedge clk) begin
    civil_date_t want;
    int          bad;
    if (!rst) begin
      if (civil.valid && civil.ready) begin
        if (dates_due.size() == 0) begin
          $error("result transfer with no date pending (packed_date %0d)", civil.packed_date);
          mismatches++;
        end else begin
          want = dates_due.pop_front();
          bad = 0;
          bad += field_differs("packed_date", want.packed_date, civil.packed_date);
          bad += field_differs("year", 27'(want.year), 27'(civil.year));
          bad += field_differs("month", 27'(want.month), 27'(civil.month));
          bad += field_differs("day_of_month", 27'(want.day_of_month), 27'(civil.day_of_month));
          bad += field_differs("day_of_week", 27'(want.day_of_week), 27'(civil.day_of_week));
          bad += field_differs("is_working_day", 27'(want.is_working_day),
                               27'(civil.is_working_day));
          bad += field_differs("valid_res", 27'(want.valid_res), 27'(civil.valid_res));
          if (bad != 0) mismatches++;
          checked++;
          if (!want.valid_res) out_of_range++;
        end
      end
      if (stamp.valid && stamp.ready) dates_due.push_back(civil_date_of(stamp.unix_seconds));
    end
    fail_count <= mismatches;
    dates_pending <= dates_due.size();
    dates_checked <= checked;
    dates_out_of_range <= out_of_range;
  end

endmodule

FILE: sim/tb_unix_seconds_to_packed_date.sv
// Top of the seconds-to-date testbench: clock, reset, stamp stimulus, output stalls, verdict.
`timescale 1ns / 100ps

module tb_unix_seconds_to_packed_date;

  localparam int RANDOM_STAMPS   = 1380;
  localparam int LONG_HOLD       = 80;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 20;
  localparam longint TOTAL_DAYS  = 3652059;
  localparam longint FIRST_DAY   = -719162;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   dst_idle_pct;
  logic hold_civil_req;
  int   quiet_cycles;
  int   stamps_sent;
  int   fail_count;
  int   dates_pending;
  int   dates_checked;
  int   dates_out_of_range;

  upd_in_if  stamp ();
  upd_out_if civil ();

  unix_seconds_to_packed_date dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp),
    .civil (civil)
  );

  civil_date_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .stamp              (stamp),
    .civil              (civil),
    .fail_count         (fail_count),
    .dates_pending      (dates_pending),
    .dates_checked      (dates_checked),
    .dates_out_of_range (dates_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one stamp, idling first at the current sender rate, and hold it until transfer
  task automatic send_stamp(input logic signed [63:0] secs);
    while ($urandom_range(99) < src_idle_pct) begin
      stamp.valid <= 1'b0;
      @(posedge clk);
    end
    stamp.valid <= 1'b1;
    stamp.unix_seconds <= secs;
    @(posedge clk);
    while (!stamp.ready) @(posedge clk);
    stamps_sent++;
  endtask

  // Drop valid and hold off until every pending date has come back
  task automatic drain_dates();
    stamp.valid <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);
  endtask

  // Pick a timestamp: mostly in range, plus day edges, range edges and raw 64-bit noise
  function automatic logic signed [63:0] random_stamp();
    logic [63:0] span;
    logic [63:0] raw;
    longint      day;
    int          pick;
    pick = $urandom_range(99);
    raw = {$urandom, $urandom};
    span = 64'(upd_pkg::SEC_HI - upd_pkg::SEC_LO) + 64'd1;
    if (pick < 55) return upd_pkg::SEC_LO + signed'(raw % span);
    if (pick < 75) begin
      day = longint'($urandom_range(TOTAL_DAYS - 1)) + FIRST_DAY;
      case ($urandom_range(3))
        0:       return day * 86400 - 1;
        1:       return day * 86400;
        2:       return day * 86400 + 1;
        default: return day * 86400 + 86399;
      endcase
    end
    if (pick < 85) begin
      day = longint'($urandom_range(200000)) - 100000;
      return ($urandom_range(1) == 0) ? upd_pkg::SEC_LO + day : upd_pkg::SEC_HI + day;
    end
    return signed'(raw);
  endfunction

  // Drive the result ready line; a requested hold keeps it low for a long stretch
  initial begin
    civil.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_civil_req) begin
        hold_civil_req = 1'b0;
        civil.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        civil.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (stamp.valid && stamp.ready) || (civil.valid && civil.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed stamps: day and range edges, leap days, century rules, extreme words
  logic signed [63:0] directed_stamps [] = '{
    64'sd0, -64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
    upd_pkg::SEC_LO, upd_pkg::SEC_LO - 64'sd1, upd_pkg::SEC_HI, upd_pkg::SEC_HI + 64'sd1,
    64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
    64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
    64'sd951782400,      // 2000-02-29
    -64'sd2203977600,    // 1900-02-28
    -64'sd2203891200,    // 1900-03-01
    64'sd1709164800,     // 2024-02-29
    64'sd946598400,      // 1999-12-31
    64'sd2147483648,     // one past the 32-bit rollover
    -64'sd62104060800    // 0002-01-01
  };

  initial begin
    int phase;
    int n;
    rst = 1'b1;
    stamp.valid = 1'b0;
    stamp.unix_seconds = '0;
    hold_civil_req = 1'b0;
    quiet_cycles = 0;
    stamps_sent = 0;
    src_idle_pct = 17;
    dst_idle_pct = 68;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);
    drain_dates();

    // Three idle mixes; the last also gets a long output hold while stamps keep coming
    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 68 : 0;
      dst_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 17 : 0;
      if (phase == 2) hold_civil_req = 1'b1;
      for (n = 0; n < RANDOM_STAMPS / 3; n++) send_stamp(random_stamp());
      drain_dates();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d stamps (directed edges, in-range, day-edge, range-edge and raw words);",
             stamps_sent);
    $display("checked %0d dates, %0d of them out of range, under three stall mixes.",
             dates_checked, dates_out_of_range);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: unix_seconds_to_packed_date.f
rtl/upd_pkg.sv
rtl/upd_in_if.sv
rtl/upd_out_if.sv
rtl/upd_day_stage.sv
rtl/upd_era_stage.sv
rtl/upd_civil_stage.sv
rtl/unix_seconds_to_packed_date.sv
sim/tb_civil_date_checker.sv
sim/tb_unix_seconds_to_packed_date.sv
